// ===== hdl/free_slot_stack_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Free slot stack allocator assertion macros
// Clocked assertion shorthands shared by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef FREE_SLOT_STACK_ALLOCATOR_MACROS_SVH
`define FREE_SLOT_STACK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define FSSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fssa: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define FSSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fssa: next-cycle check failed");

`endif

// ===== hdl/fssa_pkg.sv =====
// ----------------------------------------------------------------------------
// Free slot stack allocator package
// Pool geometry, field widths, action and status codes, control structs.
// ----------------------------------------------------------------------------
package fssa_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int ADDR_W     = $clog2(SLOT_COUNT);
    localparam int TOP_W      = ADDR_W + 1;
    localparam int SLOT_W     = 8;
    localparam int COUNT_W    = 8;
    localparam int FREE_W     = 9;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_COUNT = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    localparam logic [COUNT_W-1:0] ONE_REQUEST = COUNT_W'(1);

    // controller to datapath
    typedef struct packed {
        logic       pop_read;   // read stack entry at top
        logic       pop_done;   // advance top, load result with read slot
        logic       push;       // retreat top, store returned slot
        logic       clear;      // refill pool
        logic       res_load;   // load result with status, no slot
        logic [1:0] status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic res_free;         // result register can take a beat next edge
    } dp_sts_t;

endpackage

// ===== hdl/fssa_if.sv =====
// ----------------------------------------------------------------------------
// Free slot stack allocator channels
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
interface fssa_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] request_count;
    logic       slot_valid;
    logic [7:0] slot_index;

    modport source (output valid, output action, output request_count,
                    output slot_valid, output slot_index, input ready);
    modport sink   (input valid, input action, input request_count,
                    input slot_valid, input slot_index, output ready);
endinterface

interface fssa_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] granted_slot;
    logic [1:0] status;
    logic [8:0] free_count;

    modport source (output valid, output granted_slot, output status,
                    output free_count, input ready);
    modport sink   (input valid, input granted_slot, input status,
                    input free_count, output ready);
endinterface

// ===== hdl/fssa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Free slot stack allocator controller
// Decodes request beats into datapath commands; sequences the stack read.
// ----------------------------------------------------------------------------
`include "free_slot_stack_allocator_macros.svh"

module fssa_ctrl
    import fssa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fssa_req_if.sink      req,
    output dp_cmd_t       cmd,
    input  dp_sts_t       sts
);

    typedef enum logic {S_IDLE, S_LOOKUP} state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready;

    assign req.ready = ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ready = sts.res_free;
                if (req.valid && sts.res_free)
                begin
                    case (req.action)
                        ACT_ALLOC:
                        begin
                            if (req.request_count != ONE_REQUEST)
                            begin
                                cmd.res_load = 1'b1;
                                cmd.status   = ST_BAD_COUNT;
                            end
                            else if (sts.full)
                            begin
                                cmd.res_load = 1'b1;
                                cmd.status   = ST_EXHAUSTED;
                            end
                            else
                            begin
                                cmd.pop_read = 1'b1;
                                state_next   = S_LOOKUP;
                            end
                        end
                        ACT_FREE:
                        begin
                            cmd.res_load = 1'b1;
                            cmd.status   = ST_OK;
                            // null free does nothing, even on a full pool
                            if (req.slot_valid)
                            begin
                                if (sts.empty)
                                    cmd.status = ST_UNDERFLOW;
                                else
                                    cmd.push = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            cmd.clear    = 1'b1;
                            cmd.res_load = 1'b1;
                            cmd.status   = ST_OK;
                        end
                        default:
                        begin
                            cmd.res_load = 1'b1;
                            cmd.status   = ST_OK;
                        end
                    endcase
                end
            end
            S_LOOKUP:
            begin
                cmd.pop_done = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `FSSA_ASSERT_NOW(a_lookup_has_room, clk, rst_n, state_reg == S_LOOKUP, sts.res_free)
    `FSSA_ASSERT_NOW(a_no_accept_in_lookup, clk, rst_n, state_reg == S_LOOKUP, !req.ready)
    `FSSA_ASSERT_NEXT(a_pop_then_done, clk, rst_n, cmd.pop_read, cmd.pop_done)

endmodule

// ===== hdl/fssa_dp.sv =====
// ----------------------------------------------------------------------------
// Free slot stack allocator datapath
// Slot stack memory, top pointer, per-entry written flags, result register.
// ----------------------------------------------------------------------------
`include "free_slot_stack_allocator_macros.svh"

module fssa_dp
    import fssa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] slot_index,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    fssa_rsp_if.source        rsp
);

    logic [SLOT_W-1:0]     stack_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] written_reg;
    logic [TOP_W-1:0]      top_reg;
    logic [TOP_W-1:0]      top_next;
    logic [TOP_W-1:0]      top_inc;
    logic [TOP_W-1:0]      top_dec;
    logic [SLOT_W-1:0]     rd_data_reg;
    logic [SLOT_W-1:0]     rd_index_reg;
    logic                  rd_hit_reg;
    logic [SLOT_W-1:0]     rd_slot;
    logic                  res_valid_reg;
    logic [SLOT_W-1:0]     granted_reg;
    logic [1:0]            status_reg;
    logic [FREE_W-1:0]     free_reg;
    logic [FREE_W-1:0]     free_next;
    logic                  res_take;

    assign top_inc  = top_reg + 1'b1;
    assign top_dec  = top_reg - 1'b1;
    assign res_take = res_valid_reg && rsp.ready;

    always_comb
    begin
        top_next = top_reg;
        if (cmd.clear)
            top_next = '0;
        else if (cmd.push)
            top_next = top_dec;
        else if (cmd.pop_done)
            top_next = top_inc;
    end

    assign free_next = FREE_W'(TOP_W'(SLOT_COUNT) - top_next);

    // an entry never written since reset or clear holds its own slot number
    assign rd_slot = rd_hit_reg ? rd_data_reg : rd_index_reg;

    assign sts.empty    = (top_reg == '0);
    assign sts.full     = (top_reg == TOP_W'(SLOT_COUNT));
    assign sts.res_free = !res_valid_reg || rsp.ready;

    assign rsp.valid        = res_valid_reg;
    assign rsp.granted_slot = granted_reg;
    assign rsp.status       = status_reg;
    assign rsp.free_count   = free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            written_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg <= top_next;
            if (cmd.clear)
                written_reg <= '0;
            else if (cmd.push)
                written_reg[top_dec[ADDR_W-1:0]] <= 1'b1;
            if (cmd.res_load || cmd.pop_done)
                res_valid_reg <= 1'b1;
            else if (res_take)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stack_mem[top_dec[ADDR_W-1:0]] <= slot_index;
        if (cmd.pop_read)
            rd_data_reg <= stack_mem[top_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop_read)
        begin
            rd_hit_reg   <= written_reg[top_reg[ADDR_W-1:0]];
            rd_index_reg <= SLOT_W'(top_reg[ADDR_W-1:0]);
        end
        if (cmd.pop_done)
        begin
            granted_reg <= rd_slot;
            status_reg  <= ST_OK;
            free_reg    <= free_next;
        end
        else if (cmd.res_load)
        begin
            granted_reg <= '0;
            status_reg  <= cmd.status;
            free_reg    <= free_next;
        end
    end

    `FSSA_ASSERT_NOW(a_top_in_range, clk, rst_n, 1'b1, top_reg <= TOP_W'(SLOT_COUNT))
    `FSSA_ASSERT_NOW(a_pop_not_full, clk, rst_n, cmd.pop_read, !sts.full)
    `FSSA_ASSERT_NOW(a_push_not_empty, clk, rst_n, cmd.push, !sts.empty)
    `FSSA_ASSERT_NEXT(a_pop_advances, clk, rst_n, cmd.pop_done, top_reg == TOP_W'($past(top_reg) + 1'b1))

endmodule

// ===== hdl/free_slot_stack_allocator.sv =====
// ----------------------------------------------------------------------------
// Free slot stack allocator
// Pool of slots kept as a stack of free slot numbers: allocate, free, clear.
// ----------------------------------------------------------------------------
//   channel  role    payload
//   req      sink    action, request_count, slot_valid, slot_index
//   rsp      source  granted_slot, status, free_count
//
// A good allocate passes through S_LOOKUP: the stack memory read is registered.
// Every other beat (free, clear, rejected allocate) is answered straight from S_IDLE.
// After reset and after clear, per-entry written flags make each stack
// entry read as its own slot number; there is no memory clearing pass.
// One result register: a new beat is taken in the cycle the held result leaves.
// ----------------------------------------------------------------------------
module free_slot_stack_allocator
    import fssa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fssa_req_if.sink   req,
    fssa_rsp_if.source rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    fssa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts)
    );

    fssa_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_index (req.slot_index),
        .cmd        (cmd),
        .sts        (sts),
        .rsp        (rsp)
    );

endmodule

// ===== dv/free_slot_stack_allocator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Free slot stack allocator checker
// Watches the request and response channels and keeps its own copy of the
// slot stack. It predicts the answer to every accepted request beat and
// compares each response beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module free_slot_stack_allocator_checker
    import fssa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fssa_req_if  req,
    fssa_rsp_if  rsp,
    output int   outstanding,
    output int   mismatches
);

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [1:0]        status;
        logic [FREE_W-1:0] free_cnt;
    } pool_answer_t;

    logic [SLOT_W-1:0] slot_stack [SLOT_COUNT];
    logic [TOP_W-1:0]  alloc_depth;
    pool_answer_t      answers_due [$];

    function automatic void refill_pool();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_stack[i] = SLOT_W'(i);
        end
        alloc_depth = '0;
    endfunction

    // Update the stack copy for one request beat and return its answer.
    function automatic pool_answer_t apply_request(
        input logic [1:0]         action,
        input logic [COUNT_W-1:0] count,
        input logic               valid,
        input logic [SLOT_W-1:0]  slot
    );
        pool_answer_t ans;
        ans        = '0;
        ans.status = ST_OK;
        case (action)
            ACT_ALLOC:
            begin
                // count is checked before exhaustion
                if (count != ONE_REQUEST)
                    ans.status = ST_BAD_COUNT;
                else if (alloc_depth == TOP_W'(SLOT_COUNT))
                    ans.status = ST_EXHAUSTED;
                else
                begin
                    ans.slot    = slot_stack[alloc_depth[ADDR_W-1:0]];
                    alloc_depth = alloc_depth + 1'b1;
                end
            end
            ACT_FREE:
            begin
                // null free does nothing; the slot number itself is never checked
                if (valid)
                begin
                    if (alloc_depth == '0)
                        ans.status = ST_UNDERFLOW;
                    else
                    begin
                        alloc_depth = alloc_depth - 1'b1;
                        slot_stack[alloc_depth[ADDR_W-1:0]] = slot;
                    end
                end
            end
            ACT_CLEAR:
                refill_pool();
            default:
                ;
        endcase
        ans.free_cnt = FREE_W'(SLOT_COUNT - int'(alloc_depth));
        return ans;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input logic [FREE_W-1:0] got);
        if (got !== FREE_W'(want))
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pool_answer_t due;
        if (!rst_n)
        begin
            refill_pool();
            answers_due.delete();
            outstanding <= 0;
            mismatches  = 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("response beat with no request pending");
                    mismatches++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    check_field("granted_slot", due.slot, FREE_W'(rsp.granted_slot));
                    check_field("status", due.status, FREE_W'(rsp.status));
                    check_field("free_count", due.free_cnt, rsp.free_count);
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                answers_due = {answers_due, apply_request(req.action, req.request_count,
                                                          req.slot_valid, req.slot_index)};
            outstanding <= answers_due.size();
        end
    end

endmodule

// ===== dv/free_slot_stack_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Free slot stack allocator testbench
// Drives directed corner beats, then long fill, drain and mixed sequences of
// allocate, free and clear with random gaps and stalls on both channels.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module free_slot_stack_allocator_tb;
    import fssa_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_BEATS = 1230;
    localparam int         HOLD_AT      = 800;
    localparam int         HOLD_LEN     = 400;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_t;

    logic clk = 1'b0;
    logic rst_n;
    int   outstanding;
    int   mismatches;
    bit   tx_steady = 1'b0;

    fssa_req_if req_if ();
    fssa_rsp_if rsp_if ();

    free_slot_stack_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    free_slot_stack_allocator_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always #6 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Call at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic [1:0] action, input logic [COUNT_W-1:0] count,
                             input logic valid, input logic [SLOT_W-1:0] slot);
        int unsigned gap;
        gap = tx_steady ? 0 : next_gap();
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.action        <= action;
        req_if.request_count <= count;
        req_if.slot_valid    <= valid;
        req_if.slot_index    <= slot;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
    endtask

    task automatic send_random(input mix_t mix);
        int unsigned r;
        int unsigned alloc_lim;
        int unsigned bad_lim;
        int unsigned free_lim;
        int unsigned unused_lim;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                alloc_lim  = 86;
                bad_lim    = 90;
                free_lim   = 98;
                unused_lim = 100;
            end
            MIX_DRAIN:
            begin
                alloc_lim  = 8;
                bad_lim    = 10;
                free_lim   = 97;
                unused_lim = 99;
            end
            default:
            begin
                alloc_lim  = 42;
                bad_lim    = 47;
                free_lim   = 93;
                unused_lim = 96;
            end
        endcase
        if (r < alloc_lim)
            send_beat(ACT_ALLOC, ONE_REQUEST, 1'($urandom), SLOT_W'($urandom));
        else if (r < bad_lim)
            send_beat(ACT_ALLOC, COUNT_W'($urandom), 1'($urandom), SLOT_W'($urandom));
        else if (r < free_lim)
            send_beat(ACT_FREE, COUNT_W'($urandom), $urandom_range(0, 9) != 0,
                      SLOT_W'($urandom));
        else if (r < unused_lim)
            send_beat(ACT_UNUSED, COUNT_W'($urandom), 1'($urandom), SLOT_W'($urandom));
        else
            send_beat(ACT_CLEAR, COUNT_W'($urandom), 1'($urandom), SLOT_W'($urandom));
    endtask

    // response side: random stall stretches, one long hold-off
    initial
    begin : response_ready
        int unsigned rx_cycles;
        int unsigned gap;
        int unsigned run;
        bit          held;
        rx_cycles = 0;
        held      = 1'b0;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && rx_cycles >= HOLD_AT)
            begin
                held = 1'b1;
                gap  = HOLD_LEN;
            end
            else
                gap = next_gap();
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 12);
            if (gap != 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            repeat (run) @(posedge clk);
            rx_cycles += gap + run;
        end
    end

    initial
    begin : stimulus
        mix_t        mix;
        int unsigned seg_len;
        int unsigned sent;
        int unsigned seg;
        req_if.valid         <= 1'b0;
        req_if.action        <= ACT_ALLOC;
        req_if.request_count <= '0;
        req_if.slot_valid    <= 1'b0;
        req_if.slot_index    <= '0;
        rst_n                <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner beats: rejected counts, underflow, null and unused beats, clear
        send_beat(ACT_ALLOC,  8'd0,        1'b0, 8'd0);
        send_beat(ACT_ALLOC,  8'd255,      1'b1, 8'd255);
        send_beat(ACT_ALLOC,  8'd2,        1'b0, 8'd0);
        send_beat(ACT_FREE,   8'd0,        1'b1, 8'd0);
        send_beat(ACT_FREE,   8'd255,      1'b0, 8'd255);
        send_beat(ACT_UNUSED, 8'd255,      1'b1, 8'd255);
        send_beat(ACT_ALLOC,  ONE_REQUEST, 1'b0, 8'd0);
        send_beat(ACT_ALLOC,  ONE_REQUEST, 1'b1, 8'd255);
        send_beat(ACT_FREE,   8'd0,        1'b1, 8'd255);
        send_beat(ACT_ALLOC,  ONE_REQUEST, 1'b0, 8'd0);
        send_beat(ACT_FREE,   8'd0,        1'b0, 8'd17);
        send_beat(ACT_ALLOC,  8'd128,      1'b0, 8'd0);
        send_beat(ACT_CLEAR,  8'd0,        1'b0, 8'd0);
        send_beat(ACT_ALLOC,  ONE_REQUEST, 1'b0, 8'd0);
        send_beat(ACT_FREE,   8'd0,        1'b1, 8'hAA);
        send_beat(ACT_FREE,   8'd0,        1'b1, 8'h55);
        send_beat(ACT_ALLOC,  ONE_REQUEST, 1'b0, 8'd0);
        send_beat(ACT_CLEAR,  8'd255,      1'b1, 8'd255);
        send_beat(ACT_FREE,   8'd0,        1'b0, 8'd0);
        send_beat(ACT_UNUSED, 8'd0,        1'b0, 8'd0);

        // fill to exhaustion, drain to underflow, then random mixes
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_BEATS)
        begin
            if (seg == 0)
                mix = MIX_FILL;
            else if (seg == 1)
                mix = MIX_DRAIN;
            else
                mix = mix_t'($urandom_range(0, 2));
            seg_len   = (mix == MIX_BLEND) ? $urandom_range(20, 100) : $urandom_range(330, 400);
            if (seg_len > RANDOM_BEATS - sent)
                seg_len = RANDOM_BEATS - sent;
            tx_steady = $urandom_range(0, 3) == 0;
            repeat (seg_len) send_random(mix);
            sent += seg_len;
            if (seg == 2)
            begin
                // hold the request side until the block has answered everything
                req_if.valid <= 1'b0;
                @(posedge clk);
                wait (outstanding == 0);
                @(posedge clk);
            end
            seg++;
        end

        req_if.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("free_slot_stack_allocator_tb: clean");
        else
            $display("free_slot_stack_allocator_tb: errors");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("free_slot_stack_allocator_tb: errors");
        $finish;
    end

endmodule
